[design/lfu_pkg.sv]
// Shared constants and controller/datapath interface types for the LFU slot set.
package lfu_pkg;

  localparam int DEF_MAX_SLOTS = 32;
  localparam int DEF_KEY_BITS  = 8;

  localparam int CFG_W   = 6;
  localparam int IN_KEY_W = 8;
  localparam int OUT_IDX_W = 5;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 32;

  localparam logic [CFG_W-1:0]   ACTIVE_RESET = CFG_W'(32);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [STAMP_W-1:0] STAMP_MAX    = '1;

  typedef struct packed {
    logic clear;   // item accepted: latch key, clear trackers, rewind scan
    logic step;    // issue one slot read
    logic commit;  // update the chosen slot and load the result
  } cmd_t;

  typedef struct packed {
    logic last_addr;  // current read address is the last slot
    logic out_free;   // result register can take a new item this cycle
  } status_t;

endpackage

[design/lfu_ram.sv]
// Generic simple dual-port RAM with registered read.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lfu_ctrl.sv]
// Controller state machine: sequences accept, slot scan, drain and commit.
module lfu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lfu_pkg::status_t status,
  output lfu_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    COMMIT
  } state_t;

  state_t state;

  assign in_ready   = (state == IDLE);
  assign cmd.clear  = (state == IDLE) && in_valid;
  assign cmd.step   = (state == SCAN);
  assign cmd.commit = (state == COMMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:   if (in_valid) state <= SCAN;
        SCAN:   if (status.last_addr) state <= DRAIN;
        DRAIN:  state <= COMMIT;
        COMMIT: if (status.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[design/lfu_datapath.sv]
// Datapath: slot store, scan trackers, slot update and result register.
module lfu_datapath #(
  parameter int MAX_SLOTS = lfu_pkg::DEF_MAX_SLOTS,
  parameter int KEY_BITS  = lfu_pkg::DEF_KEY_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lfu_pkg::cmd_t                  cmd,
  output lfu_pkg::status_t               status,
  input  logic [lfu_pkg::IN_KEY_W-1:0]   key_id,
  input  logic                           cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [lfu_pkg::OUT_IDX_W-1:0]  slot_index,
  output logic                           evict_valid,
  output logic [lfu_pkg::IN_KEY_W-1:0]   evicted_key,
  output logic [lfu_pkg::COUNT_W-1:0]    new_count
);

  localparam int IDXW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNTW  = $clog2(MAX_SLOTS + 1);
  localparam int CMPW  = (CNTW > lfu_pkg::CFG_W) ? CNTW : lfu_pkg::CFG_W;
  localparam int CW    = lfu_pkg::COUNT_W;
  localparam int SW    = lfu_pkg::STAMP_W;
  localparam int WORDW = KEY_BITS + CW + SW;

  // slot store and state
  logic [MAX_SLOTS-1:0]        valid;
  logic [SW-1:0]               seq;
  logic [lfu_pkg::CFG_W-1:0]   active;
  logic [KEY_BITS-1:0]         key;
  logic [IDXW-1:0]             addr;
  logic                        eval_vld;
  logic [IDXW-1:0]             eval_idx;

  // scan trackers
  logic                        found;
  logic [IDXW-1:0]             found_idx;
  logic [CW-1:0]               found_count;
  logic [SW-1:0]               found_stamp;
  logic                        vic_found;
  logic [IDXW-1:0]             vic_idx;
  logic [CW-1:0]               vic_count;
  logic [SW-1:0]               vic_stamp;
  logic [KEY_BITS-1:0]         vic_key;
  logic                        free_found;
  logic [IDXW-1:0]             free_idx;
  logic [CNTW-1:0]             used;

  logic [WORDW-1:0]            rd_data;
  logic [KEY_BITS-1:0]         rd_key;
  logic [CW-1:0]               rd_count;
  logic [SW-1:0]               rd_stamp;
  logic                        rd_less;

  logic [KEY_BITS+lfu_pkg::IN_KEY_W-1:0] key_ext;
  logic [KEY_BITS+lfu_pkg::IN_KEY_W-1:0] evk_ext;
  logic [IDXW+lfu_pkg::OUT_IDX_W-1:0]    idx_ext;

  logic                        room;
  logic [CMPW-1:0]             used_x;
  logic [CMPW-1:0]             cap_x;
  logic [IDXW-1:0]             slot;
  logic                        ev;
  logic [CW-1:0]               cnt_next;
  logic [SW-1:0]               stamp_w;
  logic [WORDW-1:0]            wr_data;

  assign key_ext  = {{KEY_BITS{1'b0}}, key_id};
  assign rd_key   = rd_data[WORDW-1 -: KEY_BITS];
  assign rd_count = rd_data[SW +: CW];
  assign rd_stamp = rd_data[SW-1:0];
  assign rd_less  = (rd_count < vic_count) ||
                    ((rd_count == vic_count) && (rd_stamp < vic_stamp));

  assign status.last_addr = (addr == IDXW'(MAX_SLOTS - 1));
  assign status.out_free  = !out_valid || out_ready;

  // capacity zero acts as one; capacity above the slot count is bounded by free_found
  assign used_x = CMPW'(used);
  assign cap_x  = (active == '0) ? CMPW'(1) : CMPW'(active);
  assign room   = free_found && (used_x < cap_x);

  always_comb begin
    slot     = vic_idx;
    ev       = 1'b0;
    cnt_next = CW'(1);
    stamp_w  = seq;
    if (found) begin
      slot     = found_idx;
      cnt_next = (found_count == lfu_pkg::COUNT_MAX) ? lfu_pkg::COUNT_MAX
                                                     : found_count + CW'(1);
      stamp_w  = found_stamp;
    end else if (room) begin
      slot = free_idx;
    end else begin
      ev = 1'b1;
    end
  end

  assign wr_data = {key, cnt_next, stamp_w};
  assign evk_ext = {{lfu_pkg::IN_KEY_W{1'b0}}, vic_key};
  assign idx_ext = {{lfu_pkg::OUT_IDX_W{1'b0}}, slot};

  lfu_ram #(
    .WIDTH (WORDW),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (slot),
    .wdata (wr_data),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      seq       <= '0;
      active    <= lfu_pkg::ACTIVE_RESET;
      eval_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        active <= cfg_data;
      end
      eval_vld <= cmd.step;
      if (cmd.commit) begin
        valid[slot] <= 1'b1;
        if (seq != lfu_pkg::STAMP_MAX) begin
          seq <= seq + SW'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      key        <= key_ext[KEY_BITS-1:0];
      addr       <= '0;
      found      <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
      used       <= '0;
    end else begin
      if (cmd.step) begin
        addr     <= addr + IDXW'(1);
        eval_idx <= addr;
      end
      if (eval_vld) begin
        if (valid[eval_idx]) begin
          used <= used + CNTW'(1);
          if (!found && (rd_key == key)) begin
            found       <= 1'b1;
            found_idx   <= eval_idx;
            found_count <= rd_count;
            found_stamp <= rd_stamp;
          end
          if (!vic_found || rd_less) begin
            vic_found <= 1'b1;
            vic_idx   <= eval_idx;
            vic_count <= rd_count;
            vic_stamp <= rd_stamp;
            vic_key   <= rd_key;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= eval_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= found;
      slot_index  <= idx_ext[lfu_pkg::OUT_IDX_W-1:0];
      evict_valid <= ev;
      evicted_key <= ev ? evk_ext[lfu_pkg::IN_KEY_W-1:0] : '0;
      new_count   <= cnt_next;
    end
  end

  a_commit_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !eval_vld && !cmd.step)
    else $error("commit while scan still running");

  a_commit_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (found || room || vic_found))
    else $error("commit without a target slot");

  a_slot_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> valid[$past(slot)])
    else $error("committed slot not marked valid");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evict_valid) && (new_count != '0))
    else $error("inconsistent result item");

endmodule

[design/lfu_slot_replacement.sv]
// Top level of the LFU slot set: channels, configuration register and submodules.
//
// Usage:
//   Input channel in_valid/in_ready carries one key_id per item. Output channel
//   out_valid/out_ready returns one result item per input: hit, slot_index,
//   evict_valid, evicted_key and new_count.
//   Config channel cfg_valid/cfg_ready writes active_slots; cfg_ready is always
//   high. Write it only while no item is in flight.
//   Each item scans every slot of the slot RAM, one read per cycle, then
//   updates the chosen slot. The result item is valid once that update is
//   committed; a new item is accepted only after the last one has committed,
//   as the slot RAM has a single read port.
//   The result register holds one finished item; the next item is accepted
//   and scanned while it waits. If the receiver still stalls at commit, the
//   block holds there until out_ready.
//   Synchronous reset empties all slots, clears the sequence stamp and sets
//   active_slots to 32. No clearing pass is needed.
module lfu_slot_replacement #(
  parameter int MAX_SLOTS = lfu_pkg::DEF_MAX_SLOTS,
  parameter int KEY_BITS  = lfu_pkg::DEF_KEY_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lfu_pkg::IN_KEY_W-1:0]   key_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [lfu_pkg::OUT_IDX_W-1:0]  slot_index,
  output logic                           evict_valid,
  output logic [lfu_pkg::IN_KEY_W-1:0]   evicted_key,
  output logic [lfu_pkg::COUNT_W-1:0]    new_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0]      active_slots
);

  lfu_pkg::cmd_t    cmd;
  lfu_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lfu_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .key_id      (key_id),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (active_slots),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .slot_index  (slot_index),
    .evict_valid (evict_valid),
    .evicted_key (evicted_key),
    .new_count   (new_count)
  );

endmodule

[sim/tb_lfu_slot_replacement.sv]
// Testbench for lfu_slot_replacement: directed and random key traffic against a predictor.
`timescale 1ns / 1ps

module tb_lfu_slot_replacement;

  localparam int SLOT_COUNT  = lfu_pkg::DEF_MAX_SLOTS;
  localparam int CYCLE_LIMIT = 800000;
  localparam int CHUNK_ITEMS = 100;

  typedef struct packed {
    logic                          hit;
    logic [lfu_pkg::OUT_IDX_W-1:0] slot;
    logic                          evict;
    logic [lfu_pkg::IN_KEY_W-1:0]  evicted;
    logic [lfu_pkg::COUNT_W-1:0]   count;
  } slot_outcome_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [lfu_pkg::IN_KEY_W-1:0]  key_id = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          hit;
  logic [lfu_pkg::OUT_IDX_W-1:0] slot_index;
  logic                          evict_valid;
  logic [lfu_pkg::IN_KEY_W-1:0]  evicted_key;
  logic [lfu_pkg::COUNT_W-1:0]   new_count;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lfu_pkg::CFG_W-1:0]     active_slots = '0;

  // predictor state
  logic                         set_valid [SLOT_COUNT];
  logic [lfu_pkg::IN_KEY_W-1:0] set_key   [SLOT_COUNT];
  logic [lfu_pkg::COUNT_W-1:0]  set_count [SLOT_COUNT];
  logic [lfu_pkg::STAMP_W-1:0]  set_stamp [SLOT_COUNT];
  logic [lfu_pkg::STAMP_W-1:0]  seq_stamp;
  logic [lfu_pkg::CFG_W-1:0]    cap_reg;

  slot_outcome_t pending_outcomes[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int result_index = 0;
  int cycle_count = 0;

  lfu_slot_replacement dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key_id      (key_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .slot_index  (slot_index),
    .evict_valid (evict_valid),
    .evicted_key (evicted_key),
    .new_count   (new_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .active_slots(active_slots)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int effective_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > SLOT_COUNT) return SLOT_COUNT;
    return int'(cap_reg);
  endfunction

  function automatic void clear_slot_set();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      set_valid[i] = 1'b0;
      set_key[i]   = '0;
      set_count[i] = '0;
      set_stamp[i] = '0;
    end
    seq_stamp = '0;
    cap_reg   = lfu_pkg::ACTIVE_RESET;
  endfunction

  // one reference: lookup, LFU victim select (lowest count, then oldest stamp, then lowest index), update
  function automatic slot_outcome_t lfu_access(input logic [lfu_pkg::IN_KEY_W-1:0] key);
    slot_outcome_t               res;
    int                          used;
    int                          found;
    int                          free_idx;
    int                          victim;
    int                          slot;
    logic [lfu_pkg::STAMP_W-1:0] stamp;
    res = '0;
    used = 0;
    found = -1;
    free_idx = -1;
    victim = -1;
    stamp = seq_stamp;
    if (seq_stamp != lfu_pkg::STAMP_MAX) seq_stamp++;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (set_valid[i]) begin
        used++;
        if (found < 0 && set_key[i] == key) found = i;
        if (victim < 0 || set_count[i] < set_count[victim] ||
            (set_count[i] == set_count[victim] && set_stamp[i] < set_stamp[victim]))
          victim = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (found >= 0) begin
      slot = found;
      res.hit = 1'b1;
      if (set_count[slot] != lfu_pkg::COUNT_MAX) set_count[slot]++;
    end else begin
      if (used < effective_capacity() && free_idx >= 0) begin
        slot = free_idx;
      end else begin
        slot = victim;
        res.evict = 1'b1;
        res.evicted = set_key[slot];
      end
      set_valid[slot] = 1'b1;
      set_key[slot]   = key;
      set_count[slot] = lfu_pkg::COUNT_W'(1);
      set_stamp[slot] = stamp;
    end
    res.slot  = lfu_pkg::OUT_IDX_W'(slot);
    res.count = set_count[slot];
    return res;
  endfunction

  always @(posedge clk) begin
    slot_outcome_t want;
    slot_outcome_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{hit, slot_index, evict_valid, evicted_key, new_count};
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: unexpected item, nothing pending", result_index);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot || got.evict !== want.evict ||
            got.evicted !== want.evicted || got.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected hit %0b slot %0d evict %0b key %0d count %0d",
                     result_index, want.hit, want.slot, want.evict, want.evicted,
                     want.count);
            $display("result %0d: got      hit %0b slot %0d evict %0b key %0d count %0d",
                     result_index, got.hit, got.slot, got.evict, got.evicted, got.count);
          end
        end
      end
      result_index++;
    end
  end

  task automatic send_key(input logic [lfu_pkg::IN_KEY_W-1:0] k);
    slot_outcome_t exp_out;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2 * SLOT_COUNT)) @(negedge clk);
    end
    in_valid <= 1'b1;
    key_id   <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_out = lfu_access(k);
    pending_outcomes.push_back(exp_out);
    @(negedge clk);
  endtask

  // only while idle: every pending result has come back
  task automatic write_capacity(input logic [lfu_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    cfg_valid    <= 1'b1;
    active_slots <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_min_capacity();
    write_capacity(6'd0);
    send_key(8'd0);
    send_key(8'd255);
    send_key(8'd255);
  endtask

  task automatic test_lfu_victim_order();
    write_capacity(6'd4);
    send_key(8'd10);
    send_key(8'd20);
    send_key(8'd30);
    send_key(8'd10);
    send_key(8'd10);
    send_key(8'd40);
  endtask

  task automatic test_capacity_lowered();
    write_capacity(6'd2);
    send_key(8'd50);
    send_key(8'd60);
  endtask

  task automatic test_capacity_clamped();
    write_capacity(6'd63);
    send_key(8'd0);
    send_key(8'd1);
    send_key(8'd128);
    send_key(8'd255);
    send_key(8'd60);
    send_key(8'd170);
  endtask

  // chunks with a fresh capacity each; keys mostly from a skewed working set
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int          mode;
    int          pool_size;
    int          a;
    int          b;
    logic [7:0]  pool_base;
    logic [5:0]  cap;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int done = 0; done < n_items; done += CHUNK_ITEMS) begin
      mode = $urandom_range(5);
      case (mode)
        0: cap = 6'd0;
        1: cap = 6'd1;
        2: cap = 6'd32;
        3: cap = 6'($urandom_range(33, 63));
        default: cap = 6'($urandom_range(2, 31));
      endcase
      write_capacity(cap);
      pool_base = 8'($urandom_range(255));
      pool_size = effective_capacity() + $urandom_range(1, 8);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        if ($urandom_range(99) < 15) begin
          send_key(8'($urandom_range(255)));
        end else begin
          a = $urandom_range(pool_size - 1);
          b = $urandom_range(pool_size - 1);
          send_key(pool_base + 8'((a < b) ? a : b));
        end
      end
    end
  endtask

  initial begin
    clear_slot_set();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct  = 10;
    recv_stall_pct = 50;
    test_min_capacity();
    test_lfu_victim_order();
    test_capacity_lowered();
    test_capacity_clamped();

    test_random_traffic(10, 50, 500);
    test_random_traffic(50, 10, 500);
    test_random_traffic(0, 0, 500);

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
